[rtl/cta_pkg.sv]
`default_nettype none
package cta_pkg;
	localparam int TRACK_SLOTS = 16;
	localparam int SLOT_W = $clog2(TRACK_SLOTS);
	localparam int LIVE_W = $clog2(TRACK_SLOTS + 1);

	typedef enum logic [1:0] {
		ST_FRAME   = 2'd0,
		ST_MATCHED = 2'd1,
		ST_NEW     = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_BELT_SPEED    = 3'd0,
		REG_CROSS_GATE    = 3'd1,
		REG_ALONG_GATE    = 3'd2,
		REG_EXIT_POSITION = 3'd3,
		REG_CONFIRM_HITS  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_OUT
	} fsm_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic        [31:0] t;
		logic        [7:0]  hits;
		logic               conf;
		logic               valid;
		logic               used;
	} track_t;

	// One detection being carried along the chain of cells.
	typedef struct packed {
		logic               active;
		logic               func;
		logic               found;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} probe_t;

	typedef struct packed {
		logic [15:0]        belt_speed;
		logic [15:0]        cross_gate;
		logic [15:0]        along_gate;
		logic signed [31:0] exit_position;
		logic [7:0]         confirm_hits;
		logic [31:0]        frame_time;
	} cfg_t;

	typedef struct packed {
		logic        matched;
		logic        alloc;
		logic [7:0]  hits;
		logic        conf;
		logic        newly;
	} cell_rep_t;
endpackage
`default_nettype wire

[rtl/cta_if.sv]
`default_nettype none
interface cta_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [31:0]        frame_time;
	logic signed [31:0] det_x;
	logic signed [31:0] det_y;
	modport source (output valid, func, frame_time, det_x, det_y, input ready);
	modport sink (input valid, func, frame_time, det_x, det_y, output ready);
endinterface

interface cta_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] slot;
	logic [7:0] hits;
	logic       confirmed;
	logic       newly_confirmed;
	logic [4:0] live_tracks;
	modport source (output valid, status, slot, hits, confirmed, newly_confirmed, live_tracks,
		input ready);
	modport sink (input valid, status, slot, hits, confirmed, newly_confirmed, live_tracks,
		output ready);
endinterface
`default_nettype wire

[rtl/conveyor_track_associator_top.sv]
`default_nettype none
// A frame start goes from acceptance straight to the output state. A detection runs
// a match pass down the chain and, if nothing matched, an allocation pass that may drop it.
// Throughput: one item at a time; the next is accepted after the result is taken.
// The probe walks the slot cells one cell a cycle, so a pass lasts as long as the chain.
// Reset (arst_n low) clears all valid and used marks, the frame time and the registers
// to their defaults; track contents are undefined until written.
module conveyor_track_associator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	cta_in_if.sink           din,
	cta_out_if.source        dout,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	cta_pkg::cfg_t cfg;
	logic [15:0] belt_speed_q, cross_gate_q, along_gate_q;
	logic signed [31:0] exit_position_q;
	logic [7:0] confirm_hits_q;
	cta_pkg::probe_t probe0;
	cta_pkg::probe_t [cta_pkg::TRACK_SLOTS:0] chain;
	cta_pkg::cell_rep_t [cta_pkg::TRACK_SLOTS-1:0] reps;
	logic [cta_pkg::TRACK_SLOTS-1:0] valids;
	logic alloc_pass, frame_clr;
	logic [31:0] ftime;
	cta_pkg::reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx = cta_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			belt_speed_q <= 16'd1288;
			cross_gate_q <= 16'd66;
			along_gate_q <= 16'd66;
			exit_position_q <= 32'sd163840;
			confirm_hits_q <= 8'd3;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			case (ridx)
				cta_pkg::REG_BELT_SPEED: belt_speed_q <= pwdata[15:0];
				cta_pkg::REG_CROSS_GATE: cross_gate_q <= pwdata[15:0];
				cta_pkg::REG_ALONG_GATE: along_gate_q <= pwdata[15:0];
				cta_pkg::REG_EXIT_POSITION: exit_position_q <= pwdata;
				cta_pkg::REG_CONFIRM_HITS: confirm_hits_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			cta_pkg::REG_BELT_SPEED: prdata = {16'd0, belt_speed_q};
			cta_pkg::REG_CROSS_GATE: prdata = {16'd0, cross_gate_q};
			cta_pkg::REG_ALONG_GATE: prdata = {16'd0, along_gate_q};
			cta_pkg::REG_EXIT_POSITION: prdata = exit_position_q;
			cta_pkg::REG_CONFIRM_HITS: prdata = {24'd0, confirm_hits_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.belt_speed = belt_speed_q;
	assign cfg.cross_gate = cross_gate_q;
	assign cfg.along_gate = along_gate_q;
	assign cfg.exit_position = exit_position_q;
	assign cfg.confirm_hits = confirm_hits_q;
	assign cfg.frame_time = ftime;

	cta_ctrl u_ctrl (
		.clk, .arst_n, .din, .dout,
		.probe(probe0), .alloc_pass, .frame_clr, .frame_time(ftime),
		.tail(chain[cta_pkg::TRACK_SLOTS]), .reps, .valids
	);

	assign chain[0] = probe0;
	for (genvar g = 0; g < cta_pkg::TRACK_SLOTS; g++) begin : g_cell
		cta_cell u_cell (
			.clk, .arst_n, .frame_clr, .cfg,
			.probe_in(chain[g]), .alloc_pass,
			.probe_out(chain[g+1]), .rep(reps[g]), .valid(valids[g])
		);
	end
endmodule
`default_nettype wire

[rtl/cta_cell.sv]
`default_nettype none
// One track slot; the probe is registered here. The first matching cell, or
// first free one in an allocation pass, claims it and marks it found below.
module cta_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            frame_clr,
	input  wire cta_pkg::cfg_t   cfg,
	input  wire cta_pkg::probe_t probe_in,
	input  wire logic            alloc_pass,
	output cta_pkg::probe_t      probe_out,
	output cta_pkg::cell_rep_t   rep,
	output logic                 valid
);
	cta_pkg::track_t trk_q;
	cta_pkg::probe_t probe_q;
	logic [31:0] elapsed;
	logic [47:0] prod;
	logic signed [49:0] dxe, dye;
	logic hit_y, hit_x, take_match, take_new;
	logic [7:0] hits_n;

	assign elapsed = cfg.frame_time - trk_q.t;
	assign prod = {32'd0, cfg.belt_speed} * {16'd0, elapsed};
	assign dye = 50'(probe_in.y) - 50'(trk_q.y);
	assign dxe = 50'(probe_in.x) - 50'(trk_q.x) - $signed({18'd0, prod[47:16]});
	assign hit_y = (dye >= -$signed({34'd0, cfg.cross_gate}))
		&& (dye <= $signed({34'd0, cfg.cross_gate}));
	assign hit_x = (dxe >= -$signed({34'd0, cfg.along_gate}))
		&& (dxe <= $signed({34'd0, cfg.along_gate}));
	assign take_match = probe_in.active && probe_in.func && !probe_in.found && !alloc_pass
		&& trk_q.valid && !trk_q.used && hit_y && hit_x;
	assign take_new = probe_in.active && probe_in.func && !probe_in.found && alloc_pass
		&& !trk_q.valid;
	assign hits_n = (trk_q.hits == 8'd255) ? trk_q.hits : trk_q.hits + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q.valid <= 1'b0;
			trk_q.used <= 1'b0;
			probe_q.active <= 1'b0;
		end else begin
			probe_q.active <= probe_in.active;
			probe_q.func <= probe_in.func;
			probe_q.found <= probe_in.found || take_match || take_new;
			probe_q.x <= probe_in.x;
			probe_q.y <= probe_in.y;
			if (frame_clr) begin
				trk_q.used <= 1'b0;
				if (trk_q.valid && trk_q.x > cfg.exit_position)
					trk_q.valid <= 1'b0;
			end else if (take_match) begin
				trk_q.used <= 1'b1;
				trk_q.x <= probe_in.x;
				trk_q.y <= probe_in.y;
				trk_q.t <= cfg.frame_time;
				trk_q.hits <= hits_n;
				if (!trk_q.conf && hits_n == cfg.confirm_hits)
					trk_q.conf <= 1'b1;
			end else if (take_new) begin
				trk_q.valid <= 1'b1;
				trk_q.used <= 1'b1;
				trk_q.x <= probe_in.x;
				trk_q.y <= probe_in.y;
				trk_q.t <= cfg.frame_time;
				trk_q.hits <= 8'd0;
				trk_q.conf <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rep.matched <= take_match;
		rep.alloc <= take_new;
		rep.hits <= take_match ? hits_n : 8'd0;
		rep.conf <= take_match && (trk_q.conf || hits_n == cfg.confirm_hits);
		rep.newly <= take_match && !trk_q.conf && hits_n == cfg.confirm_hits;
	end

	assign probe_out = probe_q;
	assign valid = trk_q.valid;
endmodule
`default_nettype wire

[rtl/cta_ctrl.sv]
`default_nettype none
// Sequencer: for a detection runs a match pass down the chain and, if
// none matched, an allocation pass; gathers the report, also for frames.
module cta_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	cta_in_if.sink                                   din,
	cta_out_if.source                                dout,
	output cta_pkg::probe_t                          probe,
	output logic                                     alloc_pass,
	output logic                                     frame_clr,
	output logic [31:0]                              frame_time,
	input  wire cta_pkg::probe_t                     tail,
	input  wire cta_pkg::cell_rep_t [cta_pkg::TRACK_SLOTS-1:0] reps,
	input  wire logic [cta_pkg::TRACK_SLOTS-1:0]     valids
);
	localparam int CNT_W = $clog2(cta_pkg::TRACK_SLOTS + 2);
	cta_pkg::fsm_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic alloc_q, func_q;
	logic signed [31:0] x_q, y_q;
	logic [31:0] ftime_q;
	logic [1:0] status_q;
	logic [cta_pkg::SLOT_W-1:0] slot_q;
	logic [7:0] hits_q;
	logic conf_q, newly_q, ovalid_q;
	logic [cta_pkg::LIVE_W-1:0] live;
	logic [cta_pkg::LIVE_W-1:0] live_acc;
	logic [cta_pkg::TRACK_SLOTS-1:0] claims;
	logic launch, pass_done;

	always_comb begin
		live_acc = '0;
		for (int i = 0; i < cta_pkg::TRACK_SLOTS; i++)
			live_acc = live_acc + cta_pkg::LIVE_W'(valids[i]);
		live = live_acc;
	end

	always_comb begin
		for (int i = 0; i < cta_pkg::TRACK_SLOTS; i++)
			claims[i] = reps[i].matched || reps[i].alloc;
	end

	assign din.ready = (state_q == cta_pkg::FSM_IDLE) && !ovalid_q;
	assign launch = state_q == cta_pkg::FSM_SCAN && cnt_q == '0;
	assign pass_done = cnt_q == CNT_W'(cta_pkg::TRACK_SLOTS);
	assign probe.active = launch;
	assign probe.func = func_q;
	assign probe.found = 1'b0;
	assign probe.x = x_q;
	assign probe.y = y_q;
	assign alloc_pass = alloc_q;
	assign frame_clr = din.valid && din.ready && !din.func;
	assign frame_time = ftime_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cta_pkg::FSM_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cta_pkg::FSM_IDLE: begin
				if (din.valid && din.ready)
					state_d = din.func ? cta_pkg::FSM_SCAN : cta_pkg::FSM_OUT;
			end
			cta_pkg::FSM_SCAN: begin
				if (pass_done && (tail.found || alloc_q))
					state_d = cta_pkg::FSM_OUT;
			end
			cta_pkg::FSM_OUT: state_d = cta_pkg::FSM_IDLE;
			default: state_d = cta_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			alloc_q <= 1'b0;
			ovalid_q <= 1'b0;
			ftime_q <= '0;
			func_q <= 1'b0;
		end else begin
			if (dout.valid && dout.ready)
				ovalid_q <= 1'b0;
			if (state_q == cta_pkg::FSM_IDLE && din.valid && din.ready) begin
				func_q <= din.func;
				x_q <= din.det_x;
				y_q <= din.det_y;
				cnt_q <= '0;
				alloc_q <= 1'b0;
				status_q <= cta_pkg::ST_FRAME;
				slot_q <= '0;
				hits_q <= '0;
				conf_q <= 1'b0;
				newly_q <= 1'b0;
				if (!din.func)
					ftime_q <= din.frame_time;
			end
			if (state_q == cta_pkg::FSM_SCAN) begin
				for (int i = 0; i < cta_pkg::TRACK_SLOTS; i++) begin
					if (reps[i].matched || reps[i].alloc) begin
						slot_q <= cta_pkg::SLOT_W'(i);
						hits_q <= reps[i].hits;
						conf_q <= reps[i].conf;
						newly_q <= reps[i].newly;
						status_q <= reps[i].matched ? cta_pkg::ST_MATCHED : cta_pkg::ST_NEW;
					end
				end
				if (pass_done) begin
					cnt_q <= '0;
					if (!tail.found && alloc_q)
						status_q <= cta_pkg::ST_DROPPED;
					alloc_q <= !tail.found;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (state_q == cta_pkg::FSM_OUT)
				ovalid_q <= 1'b1;
		end
	end

	assign dout.valid = ovalid_q;
	assign dout.status = status_q;
	assign dout.slot = 4'(slot_q);
	assign dout.hits = hits_q;
	assign dout.confirmed = conf_q;
	assign dout.newly_confirmed = newly_q;
	assign dout.live_tracks = 5'(live);

	a_one_claim: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(claims)) else $error("claims");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != cta_pkg::FSM_IDLE |-> !din.ready) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.ready |=> dout.valid) else $error("result lost");
endmodule
`default_nettype wire

[sim/conveyor_track_associator_checker.sv]
module conveyor_track_associator_checker
	import cta_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	cta_in_if.sink   din,
	cta_out_if.sink  dout,
	input wire logic        cfg_we,
	input wire logic [2:0]  cfg_idx,
	input wire logic [31:0] cfg_val,
	output int       fail_count,
	output int       pending,
	output int       beats_in,
	output int       beats_out,
	output int       stat_count [4]
);
	typedef struct packed {
		status_t    status;
		logic [3:0] slot;
		logic [7:0] hits;
		logic       confirmed;
		logic       newly;
		logic [4:0] live;
	} assoc_result_t;

	logic [15:0]        speed, ygate, xgate;
	logic signed [31:0] exit_x;
	logic [7:0]         conf_at;
	logic [31:0]        now_t;
	track_t             tab [TRACK_SLOTS];
	assoc_result_t      awaited [$];

	function automatic int live_count();
		int n;
		n = 0;
		for (int i = 0; i < TRACK_SLOTS; i++) if (tab[i].valid) n++;
		return n;
	endfunction

	task automatic associate(input logic fn, input logic [31:0] ft,
			input logic signed [31:0] dx, input logic signed [31:0] dy);
		assoc_result_t r;
		int hit, freeslot;
		logic [31:0] el;
		longint off, pred, d;
		r = '0;
		r.status = ST_FRAME;
		if (!fn) begin
			now_t = ft;
			for (int i = 0; i < TRACK_SLOTS; i++) begin
				tab[i].used = 1'b0;
				if (tab[i].valid && tab[i].x > exit_x) tab[i].valid = 1'b0;
			end
		end else begin
			hit = -1;
			for (int i = 0; i < TRACK_SLOTS && hit < 0; i++) begin
				if (tab[i].valid && !tab[i].used) begin
					el = now_t - tab[i].t;
					off = longint'((64'(speed) * 64'(el)) >> 16);
					pred = longint'(tab[i].x) + off;
					d = longint'(dy) - longint'(tab[i].y);
					if (d < 0) d = -d;
					if (d <= longint'(ygate)) begin
						d = longint'(dx) - pred;
						if (d < 0) d = -d;
						if (d <= longint'(xgate)) hit = i;
					end
				end
			end
			if (hit >= 0) begin
				tab[hit].used = 1'b1;
				tab[hit].x = dx;
				tab[hit].y = dy;
				tab[hit].t = now_t;
				if (tab[hit].hits != 8'd255) tab[hit].hits++;
				if (!tab[hit].conf && tab[hit].hits == conf_at) begin
					tab[hit].conf = 1'b1;
					r.newly = 1'b1;
				end
				r.status = ST_MATCHED;
				r.slot = hit[3:0];
				r.hits = tab[hit].hits;
				r.confirmed = tab[hit].conf;
			end else begin
				freeslot = -1;
				for (int i = TRACK_SLOTS - 1; i >= 0; i--) if (!tab[i].valid) freeslot = i;
				if (freeslot >= 0) begin
					tab[freeslot] = '{x: dx, y: dy, t: now_t, hits: 8'd0, conf: 1'b0,
						valid: 1'b1, used: 1'b1};
					r.status = ST_NEW;
					r.slot = freeslot[3:0];
				end else begin
					r.status = ST_DROPPED;
				end
			end
		end
		r.live = 5'(live_count());
		awaited = {awaited, r};
	endtask

	always @(posedge clk or negedge arst_n) begin
		assoc_result_t e;
		if (!arst_n) begin
			speed <= 16'd1288;
			ygate <= 16'd66;
			xgate <= 16'd66;
			exit_x <= 32'sd163840;
			conf_at <= 8'd3;
			now_t <= '0;
			for (int i = 0; i < TRACK_SLOTS; i++) tab[i] <= '0;
			awaited.delete();
			fail_count <= 0;
			beats_in <= 0;
			beats_out <= 0;
			for (int i = 0; i < 4; i++) stat_count[i] <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
				REG_BELT_SPEED: speed <= cfg_val[15:0];
				REG_CROSS_GATE: ygate <= cfg_val[15:0];
				REG_ALONG_GATE: xgate <= cfg_val[15:0];
				REG_EXIT_POSITION: exit_x <= cfg_val;
				REG_CONFIRM_HITS: conf_at <= cfg_val[7:0];
				default: ;
				endcase
			end
			if (dout.valid && dout.ready) begin
				beats_out <= beats_out + 1;
				if (awaited.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = awaited.pop_front();
					stat_count[e.status] <= stat_count[e.status] + 1;
					if (dout.status != e.status || dout.slot != e.slot ||
							dout.hits != e.hits || dout.confirmed != e.confirmed ||
							dout.newly_confirmed != e.newly || dout.live_tracks != e.live)
						fail_count <= fail_count + 1;
					if (dout.status != e.status)
						$error("status: expected %0d, got %0d", e.status, dout.status);
					if (dout.slot != e.slot)
						$error("slot: expected %0d, got %0d", e.slot, dout.slot);
					if (dout.hits != e.hits)
						$error("hits: expected %0d, got %0d", e.hits, dout.hits);
					if (dout.confirmed != e.confirmed)
						$error("confirmed: expected %0d, got %0d", e.confirmed,
							dout.confirmed);
					if (dout.newly_confirmed != e.newly)
						$error("newly_confirmed: expected %0d, got %0d", e.newly,
							dout.newly_confirmed);
					if (dout.live_tracks != e.live)
						$error("live_tracks: expected %0d, got %0d", e.live,
							dout.live_tracks);
				end
			end
			// The prediction runs after the pop so that a same-cycle beat is not confused.
			if (din.valid && din.ready) begin
				beats_in <= beats_in + 1;
				associate(din.func, din.frame_time, din.det_x, din.det_y);
			end
		end
	end

	assign pending = awaited.size();
endmodule

[sim/conveyor_track_associator_top_test.sv]
module conveyor_track_associator_top_test;
	import cta_pkg::*;

	localparam int MAX_QUIET = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int fail_count, pending, beats_in, beats_out;
	int stat_count [4];
	int src_idle = 0, snk_idle = 0;
	bit hold_off = 1'b0;
	int quiet = 0;
	int n_cfg = 0;
	logic [31:0] clock_t = 0;
	logic signed [31:0] obj_x [8];
	logic signed [31:0] obj_y [8];

	cta_in_if  din ();
	cta_out_if dout ();

	initial begin
		din.valid = 1'b0;
		din.func = 1'b0;
		din.frame_time = '0;
		din.det_x = '0;
		din.det_y = '0;
		dout.ready = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	conveyor_track_associator_top i_dut (
		.clk(clk), .arst_n(arst_n), .din(din.sink), .dout(dout.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	conveyor_track_associator_checker i_chk (
		.clk(clk), .arst_n(arst_n), .din(din.sink), .dout(dout.sink),
		.cfg_we(psel && penable && pwrite && pready), .cfg_idx(paddr[4:2]),
		.cfg_val(pwdata), .fail_count(fail_count), .pending(pending),
		.beats_in(beats_in), .beats_out(beats_out), .stat_count(stat_count)
	);

	always @(posedge clk) begin
		if (!arst_n || hold_off) begin
			dout.ready <= 1'b0;
		end else begin
			dout.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	always @(posedge clk) begin
		if ((din.valid && din.ready) || (dout.valid && dout.ready) || psel) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= MAX_QUIET) begin
			$display("conveyor_track_associator_top regression: fail");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		n_cfg++;
	endtask

	// The block is never ready in the cycle after a beat, so valid is dropped
	// after each accepted item, before the next one is offered.
	task automatic send(input logic fn, input logic [31:0] ft,
			input logic signed [31:0] dx, input logic signed [31:0] dy);
		while ($urandom_range(99) < src_idle) @(posedge clk);
		din.valid <= 1'b1;
		din.func <= fn;
		din.frame_time <= ft;
		din.det_x <= dx;
		din.det_y <= dy;
		@(posedge clk);
		while (!din.ready) @(posedge clk);
		din.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		while (pending != 0) @(posedge clk);
		// An idle block may still be finishing; give it the longest latency.
		repeat (2 * TRACK_SLOTS + 8) @(posedge clk);
	endtask

	task automatic frame(input logic [31:0] dt);
		clock_t = clock_t + dt;
		send(1'b0, clock_t, $urandom, $urandom);
	endtask

	// A belt scene: objects move by speed*dt/65536, jittered up to 60 each way.
	task automatic scene(input int frames, input logic [15:0] spd);
		int nobj;
		logic [31:0] dt;
		nobj = $urandom_range(1, 8);
		for (int i = 0; i < nobj; i++) begin
			obj_x[i] = $urandom_range(0, 150000);
			obj_y[i] = i * 2000 + $urandom_range(0, 500);
		end
		for (int f = 0; f < frames; f++) begin
			dt = $urandom_range(0, 200);
			frame(dt);
			for (int i = 0; i < nobj; i++) begin
				obj_x[i] = obj_x[i] + 32'((64'(spd) * 64'(dt)) >> 16);
				case ($urandom_range(9))
				0: ;
				1: send(1'b1, $urandom, $urandom, $urandom);
				default: send(1'b1, $urandom, obj_x[i] + $signed($urandom_range(0, 120)) - 60,
					obj_y[i] + $signed($urandom_range(0, 120)) - 60);
				endcase
			end
		end
	endtask

	initial begin
		int items;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: detection before any frame, gate edges, full table, exits.
		send(1'b1, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send(1'b1, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send(1'b1, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send(1'b0, 32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send(1'b1, 0, 32'sh7FFF_FFFF + 0, 32'sh8000_0000 + 66);
		send(1'b0, 32'd10, 0, 0);
		send(1'b1, 0, 32'sh8000_0000 + 12880 / 65536 * 0 + 66, 32'sh7FFF_FFFF - 67);
		send(1'b0, 0, 0, 0);
		for (int i = 0; i < 17; i++) send(1'b1, 0, i * 1000, i * 1000);
		send(1'b0, 32'd5, 0, 0);
		settle();

		write_reg(REG_BELT_SPEED, 32'd65535);
		write_reg(REG_CROSS_GATE, 32'd0);
		write_reg(REG_ALONG_GATE, 32'd65535);
		write_reg(REG_EXIT_POSITION, 32'h8000_0000);
		write_reg(REG_CONFIRM_HITS, 32'd1);
		frame(100);
		frame(0);
		settle();

		items = 0;
		for (int phase = 0; phase < 6; phase++) begin
			src_idle = (phase % 3 == 0) ? 14 : (phase % 3 == 1) ? 52 : 0;
			snk_idle = (phase % 3 == 0) ? 52 : (phase % 3 == 1) ? 14 : 0;
			case (phase)
			0: begin
				write_reg(REG_BELT_SPEED, 32'd1288);
				write_reg(REG_CROSS_GATE, 32'd66);
				write_reg(REG_ALONG_GATE, 32'd66);
				write_reg(REG_EXIT_POSITION, 32'd163840);
				write_reg(REG_CONFIRM_HITS, 32'd3);
			end
			1: begin
				write_reg(REG_CONFIRM_HITS, 32'd255);
				write_reg(REG_EXIT_POSITION, 32'h7FFF_FFFF);
				write_reg(REG_BELT_SPEED, 32'd0);
			end
			2: begin
				write_reg(REG_CONFIRM_HITS, 32'd0);
				write_reg(REG_CROSS_GATE, 32'd65535);
				write_reg(REG_ALONG_GATE, 32'd0);
			end
			default: begin
				write_reg(REG_BELT_SPEED, $urandom_range(0, 65535));
				write_reg(REG_CROSS_GATE, $urandom_range(30, 200));
				write_reg(REG_ALONG_GATE, $urandom_range(60, 400));
				write_reg(REG_EXIT_POSITION, $urandom_range(100000, 200000));
				write_reg(REG_CONFIRM_HITS, $urandom_range(1, 8));
			end
			endcase
			if (phase == 4) begin
				// Hold the result side off while the sender keeps pushing.
				fork
					begin
						hold_off = 1'b1;
						repeat (400) @(posedge clk);
						hold_off = 1'b0;
					end
					for (int k = 0; k < 6; k++) send(1'b1, 0, $urandom, $urandom);
				join
			end
			while (items < (phase + 1) * 150) begin
				scene($urandom_range(2, 6), i_chk.speed);
				items = beats_in;
			end
			settle();
		end

		$display("Covered %0d items and %0d register writes: %0d frames, %0d matches,",
			beats_in, n_cfg, stat_count[ST_FRAME], stat_count[ST_MATCHED]);
		$display("%0d new tracks and %0d drops over six idling and gate settings.",
			stat_count[ST_NEW], stat_count[ST_DROPPED]);
		if (fail_count == 0 && pending == 0)
			$display("conveyor_track_associator_top regression: pass");
		else
			$display("conveyor_track_associator_top regression: fail");
		$finish;
	end
endmodule

[files.f]
rtl/cta_pkg.sv
rtl/cta_if.sv
rtl/cta_cell.sv
rtl/cta_ctrl.sv
rtl/conveyor_track_associator_top.sv
sim/conveyor_track_associator_checker.sv
sim/conveyor_track_associator_top_test.sv
